// ===== sv/spim_pkg.sv =====
// ----------------------------------------------------------------------------
// spim_pkg: shared types and constants for the SPI register access master
// Request and result layouts, command bytes, and the OTP sequence words.
// ----------------------------------------------------------------------------
`default_nettype none

package spim_pkg;

  // Request kinds as they arrive on the input channel.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_OTP   = 2'd3
  } op_t;

  // Pin phase of the serial engine.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2,
    PH_GAP  = 2'd3
  } phase_t;

  // Sequence that the engine is running.
  typedef enum logic [1:0] {
    SEQ_NONE  = 2'd0,
    SEQ_WRITE = 2'd1,
    SEQ_READ  = 2'd2,
    SEQ_OTP   = 2'd3
  } seq_t;

  localparam int SEL_W       = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Command bytes.
  localparam logic [7:0] CMD_WRITE      = 8'h80;
  localparam logic [7:0] CMD_WRITE_WAVE = 8'hC0;
  localparam logic [7:0] CMD_READ       = 8'h00;
  localparam logic [7:0] CMD_READ_WAVE  = 8'h40;

  // OTP access registers and control values.
  localparam logic [7:0] OTP_ADDR_REG   = 8'h1D;
  localparam logic [7:0] OTP_CTRL_REG   = 8'h1B;
  localparam logic [7:0] OTP_CTRL_START = 8'h54;
  localparam logic [7:0] OTP_DATA_REG   = 8'h1E;
  localparam logic [7:0] OTP_CTRL_STOP  = 8'h50;

  // Bit index of the final clock-high phase of a transaction.
  localparam logic [4:0] LAST_BIT_WRITE = 5'd31;
  localparam logic [4:0] LAST_BIT_READ  = 5'd23;

  // OTP sequence steps.
  localparam logic [1:0] OTP_STEP_ADDR  = 2'd0;
  localparam logic [1:0] OTP_STEP_START = 2'd1;
  localparam logic [1:0] OTP_STEP_READ  = 2'd2;
  localparam logic [1:0] OTP_STEP_STOP  = 2'd3;

  // Classified request handed from the front to the engine.
  typedef struct packed {
    op_t         op;
    logic        chip;
    logic [7:0]  addr;
    logic [31:0] word;
    logic        miso;
  } req_t;

  // One result item.
  typedef struct packed {
    logic             rejected;
    logic [7:0]       read_data;
    logic             done_res;
    logic             busy_res;
    logic             mosi;
    logic             sclk;
    logic [SEL_W-1:0] select_n;
  } res_t;

  function automatic logic [31:0] write_word(input logic [7:0] addr,
                                             input logic [7:0] cmd,
                                             input logic [7:0] data);
    write_word = {addr, cmd, data, 8'h00};
  endfunction

  function automatic logic [31:0] read_word(input logic [7:0] addr,
                                            input logic [7:0] cmd);
    read_word = {addr, cmd, 16'h0000};
  endfunction

  // Serial word for one step of the OTP read sequence.
  function automatic logic [31:0] otp_word(input logic [1:0] step,
                                           input logic [7:0] otp_addr);
    case (step)
      OTP_STEP_ADDR:  otp_word = write_word(OTP_ADDR_REG, CMD_WRITE, otp_addr);
      OTP_STEP_START: otp_word = write_word(OTP_CTRL_REG, CMD_WRITE, OTP_CTRL_START);
      OTP_STEP_READ:  otp_word = read_word(OTP_DATA_REG, CMD_READ);
      default:        otp_word = write_word(OTP_CTRL_REG, CMD_WRITE, OTP_CTRL_STOP);
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== sv/spim_front.sv =====
// ----------------------------------------------------------------------------
// spim_front: request classifier
// Unpacks an input item, decodes its kind and builds the serial word.
// ----------------------------------------------------------------------------
`default_nettype none

module spim_front (
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [23:0]   in_tdata,
  input  wire logic [1:0]    in_tuser,
  input  wire logic          q_full,
  output logic               q_push,
  output spim_pkg::req_t     q_req
);

  logic       chip;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic       wave_space;
  logic       miso;

  // Field unpacking.
  assign chip       = in_tdata[0];
  assign reg_addr   = in_tdata[8:1];
  assign write_data = in_tdata[16:9];
  assign wave_space = in_tdata[17];
  assign miso       = in_tdata[18];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Classification and serial word assembly.
  always_comb begin
    q_req.op   = spim_pkg::op_t'(in_tuser);
    q_req.chip = chip;
    q_req.addr = reg_addr;
    q_req.miso = miso;
    case (spim_pkg::op_t'(in_tuser))
      spim_pkg::OP_WRITE: begin
        q_req.word = spim_pkg::write_word(reg_addr,
            wave_space ? spim_pkg::CMD_WRITE_WAVE : spim_pkg::CMD_WRITE, write_data);
      end
      spim_pkg::OP_READ: begin
        q_req.word = spim_pkg::read_word(reg_addr,
            wave_space ? spim_pkg::CMD_READ_WAVE : spim_pkg::CMD_READ);
      end
      spim_pkg::OP_OTP: begin
        q_req.word = spim_pkg::otp_word(spim_pkg::OTP_STEP_ADDR, reg_addr);
      end
      default: begin
        q_req.word = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/spim_queue.sv =====
// ----------------------------------------------------------------------------
// spim_queue: request queue
// Short first-in first-out queue between the classifier and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module spim_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire spim_pkg::req_t push_req,
  output logic                full,
  input  wire logic           pop,
  output logic                pop_valid,
  output spim_pkg::req_t      pop_req
);

  spim_pkg::req_t                    entry_r [spim_pkg::QUEUE_DEPTH];
  logic [spim_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [spim_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [spim_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                              do_pop;

  assign full      = (count_r == spim_pkg::QCNT_W'(spim_pkg::QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_req   = entry_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == spim_pkg::QPTR_W'(spim_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == spim_pkg::QPTR_W'(spim_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

`default_nettype wire

// ===== sv/spim_engine.sv =====
// ----------------------------------------------------------------------------
// spim_engine: serial engine
// Runs the SPI pin phases, the OTP sequence and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spim_engine #(
  parameter int NUM_CHIPS = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire spim_pkg::req_t q_req,
  output logic               q_pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [15:0]        out_tdata
);

  spim_pkg::phase_t  phase_r, phase_nxt;
  spim_pkg::seq_t    seq_r, seq_nxt;
  logic [4:0]        bit_count_r, bit_count_nxt;
  logic [31:0]       out_shift_r, out_shift_nxt;
  logic [7:0]        in_shift_r, in_shift_nxt;
  logic              active_chip_r, active_chip_nxt;
  logic [1:0]        otp_step_r, otp_step_nxt;
  logic [7:0]        otp_addr_r, otp_addr_nxt;
  logic [7:0]        last_read_r, last_read_nxt;
  logic              done, rej;
  logic              xfer_read;
  logic              advance;
  logic              out_valid_r;
  spim_pkg::res_t    res, res_r;

  // One request is taken whenever the result register is free or drains.
  assign advance    = q_valid && (!out_valid_r || out_tready);
  assign q_pop      = advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

  assign xfer_read = (seq_r == spim_pkg::SEQ_READ) ||
                     (seq_r == spim_pkg::SEQ_OTP && otp_step_r == spim_pkg::OTP_STEP_READ);

  // Next-state logic.
  always_comb begin
    phase_nxt       = phase_r;
    seq_nxt         = seq_r;
    bit_count_nxt   = bit_count_r;
    out_shift_nxt   = out_shift_r;
    in_shift_nxt    = in_shift_r;
    active_chip_nxt = active_chip_r;
    otp_step_nxt    = otp_step_r;
    otp_addr_nxt    = otp_addr_r;
    last_read_nxt   = last_read_r;
    done            = 1'b0;
    rej             = 1'b0;
    if (q_req.op != spim_pkg::OP_TICK) begin
      if (phase_r != spim_pkg::PH_IDLE) begin
        rej = 1'b1;
      end else begin
        // New request: select asserted, first bit driven at once.
        active_chip_nxt = q_req.chip;
        out_shift_nxt   = q_req.word;
        in_shift_nxt    = '0;
        bit_count_nxt   = '0;
        phase_nxt       = spim_pkg::PH_LOW;
        case (q_req.op)
          spim_pkg::OP_WRITE: seq_nxt = spim_pkg::SEQ_WRITE;
          spim_pkg::OP_READ:  seq_nxt = spim_pkg::SEQ_READ;
          default: begin
            seq_nxt      = spim_pkg::SEQ_OTP;
            otp_addr_nxt = q_req.addr;
            otp_step_nxt = spim_pkg::OTP_STEP_ADDR;
          end
        endcase
      end
    end else begin
      case (phase_r)
        spim_pkg::PH_LOW: begin
          in_shift_nxt = {in_shift_r[6:0], q_req.miso};
          phase_nxt    = spim_pkg::PH_HIGH;
        end
        spim_pkg::PH_HIGH: begin
          if (bit_count_r >= (xfer_read ? spim_pkg::LAST_BIT_READ
                                        : spim_pkg::LAST_BIT_WRITE)) begin
            if (xfer_read) begin
              last_read_nxt = in_shift_r;
            end
            if (seq_r == spim_pkg::SEQ_OTP && otp_step_r != spim_pkg::OTP_STEP_STOP) begin
              otp_step_nxt = otp_step_r + 1'b1;
              phase_nxt    = spim_pkg::PH_GAP;
            end else begin
              phase_nxt    = spim_pkg::PH_IDLE;
              seq_nxt      = spim_pkg::SEQ_NONE;
              otp_step_nxt = spim_pkg::OTP_STEP_ADDR;
              done         = 1'b1;
            end
            bit_count_nxt = '0;
          end else begin
            bit_count_nxt = bit_count_r + 1'b1;
            out_shift_nxt = {out_shift_r[30:0], 1'b0};
            phase_nxt     = spim_pkg::PH_LOW;
          end
        end
        spim_pkg::PH_GAP: begin
          // Release gap between OTP transactions, then start the next one.
          out_shift_nxt = spim_pkg::otp_word(otp_step_r, otp_addr_r);
          in_shift_nxt  = '0;
          bit_count_nxt = '0;
          phase_nxt     = spim_pkg::PH_LOW;
        end
        default: begin
        end
      endcase
    end
  end

  // Result outputs from the updated state.
  always_comb begin
    res.select_n  = '1;
    res.sclk      = 1'b0;
    res.mosi      = 1'b0;
    if (phase_nxt == spim_pkg::PH_LOW || phase_nxt == spim_pkg::PH_HIGH) begin
      res.mosi = out_shift_nxt[31];
      res.sclk = (phase_nxt == spim_pkg::PH_HIGH);
    end
    for (int i = 0; i < spim_pkg::SEL_W; i++) begin
      res.select_n[i] = (i < NUM_CHIPS) &&
          !((phase_nxt == spim_pkg::PH_LOW || phase_nxt == spim_pkg::PH_HIGH) &&
            (int'(active_chip_nxt) < NUM_CHIPS) && (active_chip_nxt == 1'(i)));
    end
    res.busy_res  = (phase_nxt != spim_pkg::PH_IDLE);
    res.done_res  = done;
    res.read_data = last_read_nxt;
    res.rejected  = rej;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= spim_pkg::PH_IDLE;
      seq_r         <= spim_pkg::SEQ_NONE;
      bit_count_r   <= '0;
      out_shift_r   <= '0;
      in_shift_r    <= '0;
      active_chip_r <= 1'b0;
      otp_step_r    <= '0;
      otp_addr_r    <= '0;
      last_read_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (advance) begin
        phase_r       <= phase_nxt;
        seq_r         <= seq_nxt;
        bit_count_r   <= bit_count_nxt;
        out_shift_r   <= out_shift_nxt;
        in_shift_r    <= in_shift_nxt;
        active_chip_r <= active_chip_nxt;
        otp_step_r    <= otp_step_nxt;
        otp_addr_r    <= otp_addr_nxt;
        last_read_r   <= last_read_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_tready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.done_res |-> !res_r.busy_res)
    else $error("completion reported while still busy");
  a_done_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.done_res && res_r.rejected))
    else $error("request both completed and rejected");
  a_gap_otp: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == spim_pkg::PH_GAP |-> seq_r == spim_pkg::SEQ_OTP)
    else $error("release gap outside an OTP sequence");
  a_shift_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == spim_pkg::PH_LOW || phase_r == spim_pkg::PH_HIGH) |->
    seq_r != spim_pkg::SEQ_NONE)
    else $error("shifting with no active sequence");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(phase_r) && $stable(res_r))
    else $error("engine advanced while result stalled");
`endif

endmodule

`default_nettype wire

// ===== sv/spi_register_access_master.sv =====
// ----------------------------------------------------------------------------
// spi_register_access_master: SPI mode 0 register access master
// Classifier, request queue and serial engine for register and OTP access.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the in_ channel is a tick (kind 0) or a register write,
//   register read or OTP read. Ticks pace the SPI pins: every tick moves the
//   engine one pin phase. A request that arrives while a transaction or OTP
//   sequence is running is dropped and flagged as rejected.
//   Every request produces exactly one result on the out_ channel carrying
//   the pin levels, busy, done, the last read byte and the rejected flag.
//   Throughput is one request per clock cycle while the receiver keeps up. A
//   request enters the queue on the edge it is accepted; the engine then takes
//   it from the queue and registers its result in the output register.
//   When the receiver stalls, the result register holds and the engine waits;
//   the two-entry queue keeps taking requests until it is full, and then
//   in_tready drops.
//   After reset the engine is idle and the last read byte is zero; the result
//   register is not reset, and out_tvalid stays low until the first result.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_register_access_master #(
  parameter int NUM_CHIPS = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // chip [0], reg_addr [8:1], write_data [16:9], wave_space [17], miso [18]
  input  wire logic [23:0] in_tdata,
  // kind [1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // select_n [1:0], sclk [2], mosi [3], busy_res [4], done_res [5],
  // read_data [13:6], rejected [14]
  output logic [15:0]      out_tdata
);

  spim_pkg::req_t push_req;
  spim_pkg::req_t pop_req;
  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;

  spim_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_req     (push_req)
  );

  spim_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_req  (push_req),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_req   (pop_req)
  );

  spim_engine #(
    .NUM_CHIPS (NUM_CHIPS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_req      (pop_req),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== sim/spi_register_access_master_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spi_register_access_master_tb: self-checking bench for the SPI access master
// Drives register writes, register reads and OTP reads from both chips through
// full pin sequences, paced by ticks, with requests refused while the engine
// is busy. A behavioral copy of the engine predicts the pin levels, status
// flags and read byte for every request, and each result is compared against
// it in order under several mixes of idle cycles on both channels.
// ----------------------------------------------------------------------------

module spi_register_access_master_tb;
  import spim_pkg::*;

  localparam int          CHIP_COUNT  = 2;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_PRINTS  = 30;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = OP_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  // Idle mix of both channels, in percent of cycles.
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;

  // Receiver hold-off: the stimulus bumps the ticket, the ready process serves it.
  int unsigned hold_ticket = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;

  // Behavioral copy of the serial engine.
  phase_t      eng_phase  = PH_IDLE;
  seq_t        eng_seq    = SEQ_NONE;
  logic [4:0]  bit_idx    = '0;
  logic [31:0] tx_word    = '0;
  logic [7:0]  rx_byte    = '0;
  logic        eng_chip   = 1'b0;
  logic [1:0]  otp_idx    = '0;
  logic [7:0]  otp_addr_q = '0;
  logic [7:0]  last_byte  = '0;

  // Pin levels and flags still owed by the block, oldest first.
  res_t pin_expect_q[$];
  res_t seen_pins;
  res_t want_pins;

  int unsigned mismatch_count = 0;
  int unsigned checked_count  = 0;
  int unsigned cycle_count    = 0;
  int unsigned n_writes       = 0;
  int unsigned n_reads        = 0;
  int unsigned n_otp          = 0;
  int unsigned n_refused      = 0;

  always #5 clk = ~clk;

  spi_register_access_master #(.NUM_CHIPS(CHIP_COUNT)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // ---------------------------------------------------------------------------
  // Engine prediction
  // ---------------------------------------------------------------------------

  function automatic void load_frame(input logic [31:0] word);
    tx_word   = word;
    rx_byte   = '0;
    bit_idx   = '0;
    eng_phase = PH_LOW;
  endfunction

  // Frame for the current step of the OTP read chain.
  function automatic void load_otp_frame();
    case (otp_idx)
      OTP_STEP_ADDR:  load_frame({OTP_ADDR_REG, CMD_WRITE, otp_addr_q, 8'h00});
      OTP_STEP_START: load_frame({OTP_CTRL_REG, CMD_WRITE, OTP_CTRL_START, 8'h00});
      OTP_STEP_READ:  load_frame({OTP_DATA_REG, CMD_READ, 16'h0000});
      default:        load_frame({OTP_CTRL_REG, CMD_WRITE, OTP_CTRL_STOP, 8'h00});
    endcase
  endfunction

  function automatic logic is_read_frame();
    return eng_seq == SEQ_READ || (eng_seq == SEQ_OTP && otp_idx == OTP_STEP_READ);
  endfunction

  // Advances the engine by one request and returns the result it produces.
  function automatic res_t advance_pins(input op_t kind, input logic chip,
                                        input logic [7:0] addr, input logic [7:0] data,
                                        input logic wave, input logic miso);
    res_t       r;
    logic [4:0] final_bit;
    r = '0;
    if (kind != OP_TICK) begin
      if (eng_phase != PH_IDLE) begin
        r.rejected = 1'b1;
        n_refused++;
      end else begin
        eng_chip = chip;
        case (kind)
          OP_WRITE: begin
            eng_seq = SEQ_WRITE;
            load_frame({addr, wave ? CMD_WRITE_WAVE : CMD_WRITE, data, 8'h00});
            n_writes++;
          end
          OP_READ: begin
            eng_seq = SEQ_READ;
            load_frame({addr, wave ? CMD_READ_WAVE : CMD_READ, 16'h0000});
            n_reads++;
          end
          default: begin
            eng_seq    = SEQ_OTP;
            otp_addr_q = addr;
            otp_idx    = OTP_STEP_ADDR;
            load_otp_frame();
            n_otp++;
          end
        endcase
      end
    end else begin
      case (eng_phase)
        PH_LOW: begin
          rx_byte   = {rx_byte[6:0], miso};
          eng_phase = PH_HIGH;
        end
        PH_HIGH: begin
          final_bit = is_read_frame() ? LAST_BIT_READ : LAST_BIT_WRITE;
          if (bit_idx >= final_bit) begin
            if (is_read_frame()) last_byte = rx_byte;
            // Mid-chain frames end in a gap with the select released.
            if (eng_seq == SEQ_OTP && otp_idx != OTP_STEP_STOP) begin
              otp_idx++;
              eng_phase = PH_GAP;
            end else begin
              eng_phase  = PH_IDLE;
              eng_seq    = SEQ_NONE;
              otp_idx    = '0;
              r.done_res = 1'b1;
            end
            bit_idx = '0;
          end else begin
            bit_idx++;
            tx_word   = tx_word << 1;
            eng_phase = PH_LOW;
          end
        end
        PH_GAP: load_otp_frame();
        default: ;
      endcase
    end

    r.select_n = '1;
    if (eng_phase == PH_LOW || eng_phase == PH_HIGH) begin
      if (int'(eng_chip) < CHIP_COUNT) r.select_n[eng_chip] = 1'b0;
      r.mosi = tx_word[31];
      r.sclk = (eng_phase == PH_HIGH);
    end
    r.busy_res  = (eng_phase != PH_IDLE);
    r.read_data = last_byte;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driving
  // ---------------------------------------------------------------------------

  // Offers one request, starting at a falling edge and returning at the one
  // after its acceptance, with valid still high.
  task automatic send_item(input op_t kind, input logic chip, input logic [7:0] addr,
                           input logic [7:0] data, input logic wave, input logic miso);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'b0, miso, wave, data, addr, chip};
    do @(posedge clk); while (!in_tready);
    pin_expect_q.push_back(advance_pins(kind, chip, addr, data, wave, miso));
    @(negedge clk);
  endtask

  task automatic send_tick(input int unsigned ones_pct);
    send_item(OP_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 1'($urandom_range(1)),
              $urandom_range(99) < ones_pct);
  endtask

  task automatic send_request(input op_t kind);
    send_item(kind, 1'($urandom_range(1)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // Ticks until the engine is idle again.
  task automatic finish_transfer(input int unsigned ones_pct);
    while (eng_phase != PH_IDLE) send_tick(ones_pct);
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ticks with nothing running leave the pins at rest.
  task automatic test_idle_ticks();
    send_item(OP_TICK, 1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1);
    send_item(OP_TICK, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0);
  endtask

  task automatic test_write_frames();
    send_item(OP_WRITE, 1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1);
    finish_transfer(50);
  endtask

  task automatic test_read_frames();
    send_item(OP_READ, 1'b1, 8'hFF, 8'h00, 1'b1, 1'b0);
    finish_transfer(100);
    send_item(OP_READ, 1'b0, 8'h00, 8'hFF, 1'b0, 1'b1);
    finish_transfer(0);
  endtask

  // Every kind of request is refused while a transfer is under way.
  task automatic test_busy_rejects();
    send_item(OP_READ, 1'b1, 8'h3C, 8'hC3, 1'b0, 1'b1);
    repeat (5) send_tick(50);
    send_request(OP_WRITE);
    send_request(OP_READ);
    send_request(OP_OTP);
    finish_transfer(100);
  endtask

  // Full OTP chain, with a request refused in the gap between two frames.
  task automatic test_otp_read();
    send_item(OP_OTP, 1'b1, 8'hC7, 8'h00, 1'b1, 1'b0);
    while (eng_phase != PH_GAP) send_tick(50);
    send_request(OP_READ);
    finish_transfer(50);
  endtask

  // Well-formed transfers with random content, some refused requests mixed in.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (eng_phase == PH_IDLE) begin
        if (pick < 8) begin
          send_tick(50);
        end else begin
          sent++;
          if (pick < 50) send_request(OP_WRITE);
          else if (pick < 92) send_request(OP_READ);
          else send_request(OP_OTP);
        end
      end else begin
        sent++;
        if (pick < 4) send_request(op_t'($urandom_range(1, 3)));
        else send_tick(50);
      end
    end
  endtask

  // The receiver holds off while requests keep coming, so the input stalls.
  task automatic test_backpressure();
    finish_transfer(50);
    hold_ticket++;
    send_request(OP_READ);
    finish_transfer(50);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("mismatch at result %0d: %s is %0h, predicted %0h",
               checked_count, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_pins = res_t'(out_tdata[14:0]);
      if (pin_expect_q.size() == 0) begin
        flag_mismatch("result with nothing pending", seen_pins, 0);
      end else begin
        want_pins = pin_expect_q.pop_front();
        if (seen_pins.select_n !== want_pins.select_n)
          flag_mismatch("select_n", seen_pins.select_n, want_pins.select_n);
        if (seen_pins.sclk !== want_pins.sclk)
          flag_mismatch("sclk", seen_pins.sclk, want_pins.sclk);
        if (seen_pins.mosi !== want_pins.mosi)
          flag_mismatch("mosi", seen_pins.mosi, want_pins.mosi);
        if (seen_pins.busy_res !== want_pins.busy_res)
          flag_mismatch("busy_res", seen_pins.busy_res, want_pins.busy_res);
        if (seen_pins.done_res !== want_pins.done_res)
          flag_mismatch("done_res", seen_pins.done_res, want_pins.done_res);
        if (seen_pins.read_data !== want_pins.read_data)
          flag_mismatch("read_data", seen_pins.read_data, want_pins.read_data);
        if (seen_pins.rejected !== want_pins.rejected)
          flag_mismatch("rejected", seen_pins.rejected, want_pins.rejected);
        checked_count++;
      end
    end
  end

  // Receiver ready, with random idling and the occasional long hold-off.
  always @(negedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served <= hold_ticket;
      hold_left   <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending",
               cycle_count, pin_expect_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Sender idles lightly, receiver heavily.
    send_gap_pct = 22;
    recv_gap_pct = 75;
    test_idle_ticks();
    test_write_frames();
    test_read_frames();
    test_busy_rejects();
    test_otp_read();
    test_random_traffic(15);

    // Sender idles heavily, receiver lightly.
    send_gap_pct = 75;
    recv_gap_pct = 22;
    test_random_traffic(15);

    // No idling on either side.
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_backpressure();
    test_random_traffic(15);

    idle_input();
    while (pin_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d writes, %0d reads and %0d OTP reads on both chips, %0d refused.",
             n_writes, n_reads, n_otp, n_refused);
    $display("Compared %0d results under three idle mixes and a long receiver hold-off.",
             checked_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/spim_pkg.sv
sv/spim_front.sv
sv/spim_queue.sv
sv/spim_engine.sv
sv/spi_register_access_master.sv
sim/spi_register_access_master_tb.sv
